// ===== design/md4_pkg.sv =====
package md4_pkg;

   // MD4 initial chaining words and round constants
   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] K2  = 32'h5a827999;
   localparam logic [31:0] K3  = 32'h6ed9eba1;

   localparam int STEPS = 48;
   localparam logic [5:0] LAST_STEP  = 6'(STEPS - 1);
   localparam logic [5:0] FILL_FULL  = 6'd63;
   localparam logic [5:0] FILL_LEN   = 6'd56;
   localparam logic [7:0] PAD_MARKER = 8'h80;

   localparam logic [1:0] ROUND_F = 2'd0;
   localparam logic [1:0] ROUND_G = 2'd1;
   localparam logic [1:0] ROUND_H = 2'd2;
   localparam logic [1:0] LAST_INDEX = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMP,
      ST_FOLD,
      ST_PAD,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic put_byte;     // write one byte lane at the fill position
      logic put_data;     // byte comes from the input, else padding
      logic put_marker;   // padding byte is the 0x80 marker
      logic write_length; // store bit length in words 14 and 15
      logic step_run;     // advance one compression step
      logic load_v;       // working words follow the chaining words
      logic fold;         // add working words into the chain
      logic out_next;     // one digest word transferred
      logic clear_msg;    // start a new message
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [5:0] fill;
      logic       step_last;
      logic       out_last;
   } status_type;

   // message word read by a step, per round
   function automatic logic [3:0] word_select(input logic [5:0] step);
      logic [3:0] k;
      logic [3:0] r;
      k = step[3:0];
      r = 4'b0000;
      case (step[5:4])
         ROUND_F: r = k;
         ROUND_G: r = {k[1:0], k[3:2]};
         default: r = {k[0], k[1], k[2], k[3]};
      endcase
      return r;
   endfunction

   function automatic logic [4:0] step_shift(input logic [5:0] step);
      logic [4:0] s;
      s = 5'd3;
      case ({step[5:4], step[1:0]})
         4'b0000, 4'b0100, 4'b1000: s = 5'd3;
         4'b0001: s = 5'd7;
         4'b0010: s = 5'd11;
         4'b0011: s = 5'd19;
         4'b0101: s = 5'd5;
         4'b0110: s = 5'd9;
         4'b0111: s = 5'd13;
         4'b1001: s = 5'd9;
         4'b1010: s = 5'd11;
         4'b1011: s = 5'd15;
         default: s = 5'd3;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] w;
      w = {x, x} << s;
      return w[63:32];
   endfunction

   function automatic logic [31:0] bswap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

// ===== design/md4_hash.sv =====
// MD4 digest over a byte stream, one byte per input transfer.
// A byte that completes a block starts its compression: 48 steps through a
// single step datapath, then one fold into the chain; input waits meanwhile.
// End of message: the 0x80 marker and zero padding bytes, up to 64, then the
// length words, each block compressed, then four digest word transfers.
// Synchronous active-high reset loads the initial chain and clears length/fill.
module md4_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import md4_pkg::*;

   cmd_type    cmd;
   status_type status;

   md4_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .status             (status),
      .cmd                (cmd)
   );

   md4_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_data_byte   (req_data_byte),
      .status          (status),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

// ===== design/md4_ctrl.sv =====
module md4_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_has_byte,
   input  logic                req_end_of_message,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  md4_pkg::status_type status,
   output md4_pkg::cmd_type    cmd
);
   import md4_pkg::*;

   state_type state_ff, state_in;
   logic      eom_pending_ff, eom_pending_in;
   logic      pad_first_ff, pad_first_in;
   logic      final_ff, final_in;

   // state and message flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         eom_pending_ff <= 1'b0;
         pad_first_ff   <= 1'b0;
         final_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         eom_pending_ff <= eom_pending_in;
         pad_first_ff   <= pad_first_in;
         final_ff       <= final_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      eom_pending_in = eom_pending_ff;
      pad_first_in   = pad_first_ff;
      final_in       = final_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_v  = 1'b1;
            if (req_valid) begin
               cmd.put_byte = req_has_byte;
               cmd.put_data = 1'b1;
               if (req_end_of_message) begin
                  eom_pending_in = 1'b1;
                  pad_first_in   = 1'b1;
               end
               if (req_has_byte && status.fill == FILL_FULL) begin
                  state_in = ST_COMP;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_COMP: begin
            cmd.step_run = 1'b1;
            if (status.step_last) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (final_ff) begin
               state_in = ST_OUT;
            end else if (eom_pending_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            cmd.load_v = 1'b1;
            if (pad_first_ff) begin
               cmd.put_byte = 1'b1;
               cmd.put_marker = 1'b1;
               pad_first_in = 1'b0;
               if (status.fill == FILL_FULL) begin
                  state_in = ST_COMP;
               end
            end else if (status.fill == FILL_LEN) begin
               cmd.write_length = 1'b1;
               final_in = 1'b1;
               state_in = ST_COMP;
            end else begin
               cmd.put_byte = 1'b1;
               if (status.fill == FILL_FULL) begin
                  state_in = ST_COMP;
               end
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.out_next = 1'b1;
               if (status.out_last) begin
                  cmd.clear_msg  = 1'b1;
                  eom_pending_in = 1'b0;
                  final_in       = 1'b0;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/md4_dp.sv =====
module md4_dp (
   input  logic                clock,
   input  logic                reset,
   input  md4_pkg::cmd_type    cmd,
   input  logic [7:0]          req_data_byte,
   output md4_pkg::status_type status,
   output logic [31:0]         rsp_digest_word,
   output logic [1:0]          rsp_word_index,
   output logic                rsp_last_word
);
   import md4_pkg::*;

   logic [31:0] chain_ff [4];
   logic [31:0] words_ff [16];
   logic [31:0] v_ff [4];
   logic [63:0] bit_length_ff;
   logic [5:0]  fill_ff;
   logic [5:0]  step_ff;
   logic [1:0]  index_ff;

   logic [7:0]  put_value;
   logic [31:0] a, b, c, d;
   logic [31:0] f_value;
   logic [31:0] x_value;
   logic [31:0] a_in;

   // byte to store
   always_comb begin
      if (cmd.put_data) begin
         put_value = req_data_byte;
      end else if (cmd.put_marker) begin
         put_value = PAD_MARKER;
      end else begin
         put_value = 8'h00;
      end
   end

   // one compression step: round function, add, rotate
   always_comb begin
      a = v_ff[0];
      b = v_ff[1];
      c = v_ff[2];
      d = v_ff[3];
      x_value = words_ff[word_select(step_ff)];
      case (step_ff[5:4])
         ROUND_F: f_value = (b & c) | (~b & d);
         ROUND_G: f_value = ((b & c) | (b & d) | (c & d)) + K2;
         ROUND_H: f_value = (b ^ c ^ d) + K3;
         default: f_value = (b ^ c ^ d) + K3;
      endcase
      a_in = rotl32(a + f_value + x_value, step_shift(step_ff));
   end

   // message block, byte lanes written in place
   always_ff @(posedge clock) begin
      if (cmd.put_byte) begin
         words_ff[fill_ff[5:2]][{fill_ff[1:0], 3'b000} +: 8] <= put_value;
      end
      if (cmd.write_length) begin
         words_ff[14] <= bit_length_ff[31:0];
         words_ff[15] <= bit_length_ff[63:32];
      end
   end

   // working words rotate through a, b, c, d
   always_ff @(posedge clock) begin
      if (cmd.load_v) begin
         for (int i = 0; i < 4; i++) begin
            v_ff[i] <= chain_ff[i];
         end
      end else if (cmd.step_run) begin
         v_ff[0] <= d;
         v_ff[1] <= a_in;
         v_ff[2] <= b;
         v_ff[3] <= c;
      end
   end

   // chain, length, fill, step and output index
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_msg) begin
         chain_ff[0]   <= IV0;
         chain_ff[1]   <= IV1;
         chain_ff[2]   <= IV2;
         chain_ff[3]   <= IV3;
         bit_length_ff <= '0;
         fill_ff       <= '0;
         step_ff       <= '0;
         index_ff      <= '0;
      end else begin
         if (cmd.fold) begin
            for (int i = 0; i < 4; i++) begin
               chain_ff[i] <= chain_ff[i] + v_ff[i];
            end
         end
         if (cmd.put_byte) begin
            fill_ff <= fill_ff + 6'd1;
         end
         if (cmd.put_byte && cmd.put_data) begin
            bit_length_ff <= bit_length_ff + 64'd8;
         end
         if (cmd.step_run) begin
            step_ff <= (step_ff == LAST_STEP) ? 6'd0 : step_ff + 6'd1;
         end
         if (cmd.out_next) begin
            index_ff <= index_ff + 2'd1;
         end
      end
   end

   assign status.fill      = fill_ff;
   assign status.step_last = (step_ff == LAST_STEP);
   assign status.out_last  = (index_ff == LAST_INDEX);

   assign rsp_digest_word = bswap32(chain_ff[index_ff]);
   assign rsp_word_index  = index_ff;
   assign rsp_last_word   = (index_ff == LAST_INDEX);

endmodule

// ===== design/md4_hash_checker.sv =====
module md4_hash_sva (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [1:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // last flag marks the fourth word
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 2'd3)))
      else $error("last_word does not match word_index");

   // no input taken while a digest is being delivered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted during digest output");

   // digest words follow back to back in order
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == 2'($past(rsp_word_index) + 2'd1)))
      else $error("digest word sequence broken");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_digest_word)))
      else $error("result changed while stalled");

   // reset leaves no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind md4_hash md4_hash_sva u_md4_hash_sva (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_last_word   (rsp_last_word)
);
